// ===== rtl/sawc_pkg.sv =====
`timescale 1ns / 1ps
package sawc_pkg;

   // address split, line size and backing store geometry
   localparam int ADDR_BITS   = 16;
   localparam int LINE_BYTES  = 8;
   localparam int NUM_SETS    = 16;
   localparam int OFF_W       = $clog2(LINE_BYTES);
   localparam int SET_W       = $clog2(NUM_SETS);
   localparam int TAG_W       = ADDR_BITS - OFF_W - SET_W;
   localparam int LINE_W      = 8 * LINE_BYTES;
   localparam int BACK_AW     = ADDR_BITS - OFF_W;
   localparam int BACK_DEPTH  = 1 << BACK_AW;
   localparam int DATA_W      = 8;

   // command codes
   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE
   } state_type;

   // control toward the backing store
   typedef struct packed {
      logic               rd_en;
      logic [BACK_AW-1:0] rd_addr;
      logic               wr_en;
      logic [BACK_AW-1:0] wr_addr;
      logic [LINE_W-1:0]  wr_data;
   } back_cmd_type;

endpackage

// ===== rtl/sawc_if.sv =====
`timescale 1ns / 1ps
interface sawc_req_if;
   import sawc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [ADDR_BITS-1:0] address;
   logic [DATA_W-1:0]    write_data;

   modport source (output valid, cmd, address, write_data, input ready);
   modport sink   (input valid, cmd, address, write_data, output ready);
endinterface

interface sawc_rsp_if;
   import sawc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] echo_address;
   logic [LINE_W-1:0]    line_data;
   logic                 hit;
   logic                 dirty_flag;

   modport source (output valid, echo_address, line_data, hit, dirty_flag, input ready);
   modport sink   (input valid, echo_address, line_data, hit, dirty_flag, output ready);
endinterface

// ===== rtl/set_assoc_writeback_cache.sv =====
`timescale 1ns / 1ps
// a read result is registered in the set read, lookup decision and result registers
// one request at a time, taken only after the read-modify-write of the set memory is done
// (lookup read, decision with backing access, write back of the set word)
// a result not taken stalls the next read in its update step; writes give no result
// reset: clearing pass over every line of the backing store with req not ready;
// set state is cleared at once by per-set valid flops
module set_assoc_writeback_cache #(
   parameter int NUM_WAYS = 4
) (
   input  logic       clock,
   input  logic       reset,
   sawc_req_if.sink   req_chan,
   sawc_rsp_if.source rsp_chan
);
   import sawc_pkg::*;

   localparam int WAY_W = $clog2(NUM_WAYS);
   localparam int CNT_W = $clog2(NUM_WAYS + 1);

   typedef struct packed {
      logic [NUM_WAYS-1:0][TAG_W-1:0]  tags;
      logic [NUM_WAYS-1:0][LINE_W-1:0] lines;
      logic [NUM_WAYS-1:0]             dirty;
      logic [NUM_WAYS-1:0][WAY_W-1:0]  lru;
      logic [CNT_W-1:0]                fill;
   } set_word_type;

   state_type            state_ff;
   state_type            state_in;

   // latched request
   logic                 cmd_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [DATA_W-1:0]    data_ff;
   logic [SET_W-1:0]     set_idx;
   logic [TAG_W-1:0]     tag_idx;
   logic [OFF_W-1:0]     off_idx;

   // set memory and valid flops
   set_word_type         set_mem [NUM_SETS];
   set_word_type         set_rd_ff;
   logic                 set_rd_vld_ff;
   logic [NUM_SETS-1:0]  set_vld_ff;
   set_word_type         cur;

   // lookup decision
   logic                 look_hit;
   logic [WAY_W-1:0]     look_way;
   logic                 look_dirty;
   logic                 look_full;
   logic [WAY_W-1:0]     victim;
   logic                 hit_ff;
   logic [WAY_W-1:0]     way_ff;
   logic                 dirty_ff;
   logic                 full_ff;

   // update
   logic                 accept;
   logic                 out_busy;
   logic                 upd_go;
   set_word_type         upd_word;
   logic [LINE_W-1:0]    upd_line;
   logic [WAY_W-1:0]     lru_pos;
   logic                 lru_found;

   // backing store
   back_cmd_type         back_cmd;
   logic [LINE_W-1:0]    back_rd_data;
   logic                 back_busy;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff;
   logic [LINE_W-1:0]    rsp_line_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_dirty_ff;

   assign set_idx  = addr_ff[OFF_W+SET_W-1:OFF_W];
   assign tag_idx  = addr_ff[ADDR_BITS-1:OFF_W+SET_W];
   assign off_idx  = addr_ff[OFF_W-1:0];
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_busy = rsp_valid_ff && !rsp_chan.ready;
   assign upd_go   = (state_ff == ST_UPDATE) && !(cmd_ff == CMD_READ && out_busy);

   sawc_backing u_backing (
      .clock    (clock),
      .reset    (reset),
      .back_cmd (back_cmd),
      .rd_data  (back_rd_data),
      .busy     (back_busy)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = !back_busy;
            if (req_chan.valid && !back_busy) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // request latch and set read
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_chan.cmd;
         addr_ff       <= req_chan.address;
         data_ff       <= req_chan.write_data;
         set_rd_ff     <= set_mem[req_chan.address[OFF_W+SET_W-1:OFF_W]];
         set_rd_vld_ff <= set_vld_ff[req_chan.address[OFF_W+SET_W-1:OFF_W]];
      end
   end

   // a set never written reads as empty
   always_comb begin
      cur = set_rd_ff;
      if (!set_rd_vld_ff) begin
         cur.fill = '0;
         cur.lru  = '0;
      end
   end

   // tag compare over filled ways, victim choice
   always_comb begin
      look_hit  = 1'b0;
      look_way  = '0;
      look_full = (cur.fill == CNT_W'(NUM_WAYS));
      victim    = cur.lru[NUM_WAYS-1];
      for (int k = 0; k < NUM_WAYS; k++) begin
         if (!look_hit && CNT_W'(k) < cur.fill && cur.tags[k] == tag_idx) begin
            look_hit = 1'b1;
            look_way = WAY_W'(k);
         end
      end
      if (look_hit) begin
         look_dirty = cur.dirty[look_way];
      end else if (look_full) begin
         look_way   = victim;
         look_dirty = cur.dirty[victim];
      end else begin
         look_way   = cur.fill[WAY_W-1:0];
         look_dirty = 1'b0;
      end
   end

   // eviction: write back a dirty victim and fetch the new line
   always_comb begin
      back_cmd         = '0;
      back_cmd.rd_addr = addr_ff[ADDR_BITS-1:OFF_W];
      back_cmd.wr_addr = {cur.tags[victim], set_idx};
      back_cmd.wr_data = cur.lines[victim];
      if (state_ff == ST_LOOK && !look_hit && look_full) begin
         back_cmd.rd_en = 1'b1;
         back_cmd.wr_en = cur.dirty[victim];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         hit_ff   <= look_hit;
         way_ff   <= look_way;
         dirty_ff <= look_dirty;
         full_ff  <= look_full;
      end
   end

   // new line, with byte merge on a write
   always_comb begin
      if (hit_ff) begin
         upd_line = cur.lines[way_ff];
      end else if (full_ff) begin
         upd_line = back_rd_data;
      end else begin
         // an empty way fills from a line that was never written back
         upd_line = '0;
      end
      if (cmd_ff == CMD_WRITE) begin
         for (int b = 0; b < LINE_BYTES; b++) begin
            if (OFF_W'(b) == off_idx) begin
               upd_line[8*b +: 8] = data_ff;
            end
         end
      end
   end

   function automatic logic [WAY_W-1:0] look_full_pos(input logic [CNT_W-1:0] n);
      if (n < CNT_W'(NUM_WAYS)) begin
         return n[WAY_W-1:0];
      end
      return WAY_W'(NUM_WAYS - 1);
   endfunction

   // recency list update and set word assembly
   always_comb begin
      lru_found = 1'b0;
      lru_pos   = '0;
      for (int k = NUM_WAYS - 1; k >= 0; k--) begin
         if (CNT_W'(k) < cur.fill && cur.lru[k] == way_ff) begin
            lru_found = 1'b1;
            lru_pos   = WAY_W'(k);
         end
      end
      if (!lru_found) begin
         lru_pos = look_full_pos(cur.fill);
      end
      upd_word = cur;
      for (int k = 0; k < NUM_WAYS; k++) begin
         if (k == 0) begin
            upd_word.lru[k] = way_ff;
         end else if (WAY_W'(k) <= lru_pos) begin
            upd_word.lru[k] = cur.lru[k-1];
         end
      end
      upd_word.tags[way_ff]  = tag_idx;
      upd_word.lines[way_ff] = upd_line;
      upd_word.dirty[way_ff] = (cmd_ff == CMD_WRITE) || (hit_ff && cur.dirty[way_ff]);
      if (!hit_ff && !full_ff) begin
         upd_word.fill = cur.fill + CNT_W'(1);
      end
   end

   // set memory write back
   always_ff @(posedge clock) begin
      if (upd_go) begin
         set_mem[set_idx] <= upd_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_vld_ff <= '0;
      end else if (upd_go) begin
         set_vld_ff[set_idx] <= 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (upd_go && cmd_ff == CMD_READ) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_go && cmd_ff == CMD_READ) begin
         rsp_addr_ff  <= addr_ff;
         rsp_line_ff  <= upd_line;
         rsp_hit_ff   <= hit_ff;
         rsp_dirty_ff <= dirty_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.echo_address = rsp_addr_ff;
   assign rsp_chan.line_data    = rsp_line_ff;
   assign rsp_chan.hit          = rsp_hit_ff;
   assign rsp_chan.dirty_flag   = rsp_dirty_ff;

   // a result only appears from an update step
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_UPDATE)
      else $error("result without update");

   // no request is taken during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      accept |-> !back_busy)
      else $error("request transfer during clearing");

   // fill count never passes the way count
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      upd_go |-> upd_word.fill <= CNT_W'(NUM_WAYS))
      else $error("fill count overflow");

   // an update that writes a read result never overruns a pending one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      upd_go && cmd_ff == CMD_READ |-> !out_busy)
      else $error("result overrun");
endmodule

// ===== rtl/sawc_backing.sv =====
`timescale 1ns / 1ps
module sawc_backing (
   input  logic                           clock,
   input  logic                           reset,
   input  sawc_pkg::back_cmd_type         back_cmd,
   output logic [sawc_pkg::LINE_W-1:0]    rd_data,
   output logic                           busy
);
   import sawc_pkg::*;

   logic [LINE_W-1:0]  back_mem [BACK_DEPTH];
   logic [LINE_W-1:0]  rd_data_ff;
   logic               clr_busy_ff;
   logic               clr_busy_in;
   logic [BACK_AW-1:0] clr_addr_ff;
   logic [BACK_AW-1:0] clr_addr_in;

   // clearing pass after reset, one line per cycle
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + BACK_AW'(1);
         if (clr_addr_ff == {BACK_AW{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // line store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         back_mem[clr_addr_ff] <= '0;
      end else if (back_cmd.wr_en) begin
         back_mem[back_cmd.wr_addr] <= back_cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (back_cmd.rd_en) begin
         rd_data_ff <= back_mem[back_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

   // no access may reach the store while it is being cleared
   a_no_access_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !back_cmd.rd_en && !back_cmd.wr_en)
      else $error("backing access during clearing pass");

   // a transfer pair never targets the same line twice in one cycle
   a_rd_wr_distinct: assert property (@(posedge clock) disable iff (reset)
      back_cmd.rd_en && back_cmd.wr_en |-> back_cmd.rd_addr != back_cmd.wr_addr)
      else $error("backing read and write to the same line");

   // clearing ends exactly after the last line
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> $past(clr_addr_ff) == {BACK_AW{1'b1}})
      else $error("clearing pass ended early");
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import sawc_pkg::*;

   localparam int WAYS        = 4;
   localparam int QUIET_LIMIT = 50000;  // covers the backing clear pass after reset
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_PCT    = 7;
   localparam int DRAIN_WAIT  = 16;
   localparam int PRINT_MAX   = 40;

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      logic [LINE_W-1:0]    line;
      logic                 hit;
      logic                 dirty;
   } read_result_type;

   logic clock;
   logic reset;

   sawc_req_if req_chan ();
   sawc_rsp_if rsp_chan ();

   set_assoc_writeback_cache #(.NUM_WAYS(WAYS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the cache and its backing store
   bit [TAG_W-1:0]  shadow_tags  [NUM_SETS][WAYS];
   bit [LINE_W-1:0] shadow_lines [NUM_SETS][WAYS];
   bit              shadow_dirty [NUM_SETS][WAYS];
   int unsigned     recency      [NUM_SETS][WAYS];
   int unsigned     ways_filled  [NUM_SETS];
   bit [LINE_W-1:0] backing_mem  [BACK_DEPTH];

   read_result_type pending_reads[$];
   int              error_count;
   bit              send_idles;
   bit              recv_idles;
   int              hold_request;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // move a way to the most recent slot of its set
   function automatic void promote_way(input int unsigned set_idx, input int unsigned way);
      int unsigned n;
      int unsigned pos;
      n   = ways_filled[set_idx];
      pos = n;
      for (int unsigned k = 0; k < n; k++) begin
         if (pos == n && recency[set_idx][k] == way) pos = k;
      end
      if (pos == n) pos = (n < WAYS) ? n : WAYS - 1;
      while (pos > 0) begin
         recency[set_idx][pos] = recency[set_idx][pos - 1];
         pos--;
      end
      recency[set_idx][0] = way;
   endfunction

   // apply one access to the shadow cache; reads queue their expected line
   function automatic void apply_access(input cmd_type cmd, input logic [ADDR_BITS-1:0] addr,
                                        input logic [DATA_W-1:0] data);
      logic [OFF_W-1:0]   offset;
      logic [BACK_AW-1:0] line_no;
      logic [SET_W-1:0]   set_idx;
      logic [TAG_W-1:0]   tag;
      int unsigned        n;
      int unsigned        way;
      bit                 hit;
      bit                 was_dirty;
      offset  = addr[OFF_W-1:0];
      line_no = addr[ADDR_BITS-1:OFF_W];
      set_idx = line_no[SET_W-1:0];
      tag     = line_no[BACK_AW-1:SET_W];
      n       = ways_filled[set_idx];
      hit     = 1'b0;
      way     = 0;
      for (int unsigned k = 0; k < n; k++) begin
         if (!hit && shadow_tags[set_idx][k] == tag) begin
            hit = 1'b1;
            way = k;
         end
      end
      if (hit) begin
         was_dirty = shadow_dirty[set_idx][way];
         promote_way(set_idx, way);
      end else if (n < WAYS) begin
         // empty way: filled in order, line comes from the backing store
         way = n;
         promote_way(set_idx, way);
         ways_filled[set_idx]       = n + 1;
         shadow_tags[set_idx][way]  = tag;
         shadow_lines[set_idx][way] = backing_mem[line_no];
         shadow_dirty[set_idx][way] = 1'b0;
         was_dirty = 1'b0;
      end else begin
         // full set: evict least recent, write back only a dirty victim
         way = recency[set_idx][WAYS-1];
         promote_way(set_idx, way);
         was_dirty = shadow_dirty[set_idx][way];
         if (was_dirty)
            backing_mem[{shadow_tags[set_idx][way], set_idx}] = shadow_lines[set_idx][way];
         shadow_tags[set_idx][way]  = tag;
         shadow_lines[set_idx][way] = backing_mem[line_no];
         shadow_dirty[set_idx][way] = 1'b0;
      end
      if (cmd == CMD_WRITE) begin
         shadow_lines[set_idx][way][8*offset +: 8] = data;
         shadow_dirty[set_idx][way] = 1'b1;
      end else begin
         pending_reads.push_back('{addr, shadow_lines[set_idx][way], hit, was_dirty});
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [LINE_W-1:0] got,
                                  input logic [LINE_W-1:0] want);
      if (error_count < PRINT_MAX)
         $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic check_read(input read_result_type got);
      read_result_type want;
      if (pending_reads.size() == 0) begin
         report_mismatch("unexpected line", got.line, '0);
      end else begin
         want = pending_reads.pop_front();
         if (got.address !== want.address)
            report_mismatch("echo_address", LINE_W'(got.address), LINE_W'(want.address));
         if (got.line !== want.line)
            report_mismatch("line_data", got.line, want.line);
         if (got.hit !== want.hit)
            report_mismatch("hit", LINE_W'(got.hit), LINE_W'(want.hit));
         if (got.dirty !== want.dirty)
            report_mismatch("dirty_flag", LINE_W'(got.dirty), LINE_W'(want.dirty));
      end
   endtask

   // result checking first, then prediction of the request taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_read('{rsp_chan.echo_address, rsp_chan.line_data, rsp_chan.hit,
                         rsp_chan.dirty_flag});
         if (req_chan.valid && req_chan.ready)
            apply_access(cmd_type'(req_chan.cmd), req_chan.address, req_chan.write_data);
      end
   end

   // watchdog on cycles without any transfer
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   // result side: random stalls plus long hold-offs on request
   initial begin : receiver
      int hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (recv_idles && $urandom_range(99) < IDLE_PCT) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic send_access(input cmd_type cmd, input logic [ADDR_BITS-1:0] addr,
                              input logic [DATA_W-1:0] data);
      @(negedge clock);
      while (send_idles && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= cmd;
      req_chan.address    <= addr;
      req_chan.write_data <= data;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   // mostly a handful of tags per set around a base, so sets hit and evict
   function automatic logic [ADDR_BITS-1:0] pick_address(input logic [TAG_W-1:0] base);
      logic [TAG_W-1:0] tag;
      logic [SET_W-1:0] set_idx;
      logic [OFF_W-1:0] offset;
      if ($urandom_range(99) < 15) return ADDR_BITS'($urandom);
      tag     = base ^ TAG_W'($urandom_range(0, 5));
      set_idx = SET_W'($urandom);
      offset  = OFF_W'($urandom);
      return {tag, set_idx, offset};
   endfunction

   task automatic test_fill_and_hit();
      send_access(CMD_READ,  16'h0000, 8'h00);   // empty way 0
      send_access(CMD_WRITE, 16'h0085, 8'hFF);   // empty way 1, dirty
      send_access(CMD_WRITE, 16'h0102, 8'h5A);   // empty way 2, dirty
      send_access(CMD_READ,  16'h0180, 8'h00);   // last empty way
      send_access(CMD_READ,  16'h0085, 8'h00);   // hit on a dirty way
      send_access(CMD_READ,  16'h0000, 8'h00);   // hit on a clean way
   endtask

   task automatic test_victim_selection();
      send_access(CMD_READ, 16'h0200, 8'h00);    // dirty victim written back
      send_access(CMD_READ, 16'h0280, 8'h00);    // clean victim dropped
      send_access(CMD_READ, 16'h0100, 8'h00);    // refetch of a written-back line
      send_access(CMD_READ, 16'h0085, 8'h00);    // second refetch
   endtask

   task automatic test_field_extremes();
      logic [DATA_W-1:0] data;
      for (int i = 0; i < LINE_BYTES; i++) begin
         data = (i == 0) ? 8'h00 : (i == LINE_BYTES - 1) ? 8'hFF : DATA_W'($urandom);
         send_access(CMD_WRITE, {{(ADDR_BITS-OFF_W){1'b1}}, OFF_W'(i)}, data);
      end
      send_access(CMD_READ,  16'hFFFF, 8'hFF);
      send_access(CMD_WRITE, 16'h0000, 8'hFF);
      send_access(CMD_READ,  16'h0007, 8'h00);
   endtask

   task automatic test_random_traffic(input int count);
      logic [TAG_W-1:0] base;
      cmd_type          cmd;
      base = TAG_W'($urandom);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 99) base = TAG_W'($urandom);
         cmd = ($urandom_range(99) < 55) ? CMD_READ : CMD_WRITE;
         send_access(cmd, pick_address(base), DATA_W'($urandom));
      end
   endtask

   // receiver holds off while reads keep coming, so the request side stalls
   task automatic test_back_pressure();
      logic [TAG_W-1:0] base;
      base = TAG_W'($urandom);
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 80; i++)
         send_access(CMD_READ, pick_address(base), DATA_W'($urandom));
   endtask

   task automatic test_steady_stream(input int count);
      send_idles = 1'b0;
      recv_idles = 1'b0;
      test_random_traffic(count);
      send_idles = 1'b1;
      recv_idles = 1'b1;
   endtask

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_READ;
      req_chan.address    = '0;
      req_chan.write_data = '0;
      error_count         = 0;
      hold_request        = 0;
      send_idles          = 1'b1;
      recv_idles          = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fill_and_hit();
      test_victim_selection();
      test_field_extremes();
      test_random_traffic(500);
      test_steady_stream(300);
      test_back_pressure();
      test_random_traffic(420);

      // drain outstanding reads
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sawc_pkg.sv
rtl/sawc_if.sv
rtl/sawc_backing.sv
rtl/set_assoc_writeback_cache.sv
tb/sv/tb_top.sv
